FILE: rtl/irs_pkg.sv
// Shared types and constants of the image resample interpolator.
`default_nettype none
package irs_pkg;

    // Datapath widths, sized for the widest fraction (16 bits)
    localparam int OPA_W = 34;
    localparam int OPB_W = 26;
    localparam int RES_W = 44;
    localparam int PRD_W = OPA_W + OPB_W;

    localparam logic [2:0] CFG_MODE    = 3'd0;
    localparam logic [2:0] CFG_WIDTH   = 3'd1;
    localparam logic [2:0] CFG_HEIGHT  = 3'd2;
    localparam logic [2:0] CFG_CHANNEL = 3'd3;
    localparam logic [2:0] CFG_XSTEP   = 3'd4;
    localparam logic [2:0] CFG_YSTEP   = 3'd5;

    localparam logic [1:0] MODE_CODE_NEAREST  = 2'd0;
    localparam logic [1:0] MODE_CODE_BILINEAR = 2'd1;
    localparam logic [1:0] MODE_CODE_BICUBIC  = 2'd2;

    typedef enum logic [1:0] {
        M_NEAREST,
        M_BILINEAR,
        M_BICUBIC
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POSX,
        ST_POSY,
        ST_POSL,
        ST_READ,
        ST_RWAIT,
        ST_CUBIC,
        ST_CSTORE,
        ST_BILIN,
        ST_FINAL,
        ST_DONE
    } state_t;

    // Request to the shared multiply-add unit: res = (a*b) [>>> frac] + c
    typedef struct packed {
        logic                    en;
        logic                    shift;
        logic signed [OPA_W-1:0] a;
        logic signed [OPB_W-1:0] b;
        logic signed [RES_W-1:0] c;
    } alu_req_t;

endpackage
`default_nettype wire

FILE: rtl/irs_alu.sv
// Shared multiply, shift and add unit with registered result.
`default_nettype none
module irs_alu #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                aclk,
    input  wire irs_pkg::alu_req_t                   req,
    output logic signed [irs_pkg::RES_W-1:0]         res
);

    logic signed [irs_pkg::OPA_W-1:0] a;
    logic signed [irs_pkg::OPB_W-1:0] b;
    logic signed [irs_pkg::RES_W-1:0] c;
    logic signed [irs_pkg::PRD_W-1:0] prod;
    logic signed [irs_pkg::PRD_W-1:0] prod_sh;
    logic signed [irs_pkg::RES_W-1:0] res_next;
    logic signed [irs_pkg::RES_W-1:0] res_reg;

    always_comb begin
        a        = req.a;
        b        = req.b;
        c        = req.c;
        prod     = a * b;
        prod_sh  = req.shift ? (prod >>> FRAC_BITS) : prod;
        res_next = irs_pkg::RES_W'(prod_sh) + c;
    end

    always_ff @(posedge aclk) begin
        if (req.en) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule
`default_nettype wire

FILE: rtl/irs_store.sv
// Single-port frame store with registered read data.
`default_nettype none
module irs_store #(
    parameter int DEPTH = 262144,
    parameter int AW    = 18
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic          re,
    input  wire logic [AW-1:0] addr,
    input  wire logic [7:0]    wdata,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end else if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: rtl/image_resample_interpolator.sv
// Top level of the image resample interpolator: sequencer, position and neighbour logic.
//
// Input channel s_*: an item with s_func 0 loads one source byte into the frame
// store when its row, column and channel are in range; the block stays ready.
// An item with s_func 1 is a query: it returns one resampled byte on the m_*
// channel. Configuration is written through cfg_wen/cfg_index/cfg_wdata only
// while the block is idle; the user must keep to this, the block does not enforce it.
// A query on an absent channel goes straight to its result, 0; any other query
// runs the position steps, the neighbour reads and, for bilinear and bicubic,
// the weighting before its result appears. The block takes one query at a time
// and is not ready until its result is taken. The query time is set by the
// single-port frame store (one read per cycle) and the one shared multiply-add
// unit (position, weights and every Horner step pass through it).
// A stalled receiver holds the result in m_value with m_valid high; no new item
// is taken until it is accepted.
// Reset (aresetn low, synchronous) returns the sequencer to idle and the
// registers to nearest mode, 256 x 256, 4 channels, unit steps. The frame store
// is not cleared; only loaded entries may be queried.
`default_nettype none
module image_resample_interpolator #(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 256,
    parameter int MAX_CHANNELS = 4,
    parameter int FRAC_BITS    = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_func,
    input  wire logic [11:0] s_row,
    input  wire logic [11:0] s_col,
    input  wire logic [1:0]  s_channel,
    input  wire logic [7:0]  s_sample,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_value,
    input  wire logic        cfg_wen,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [24:0] cfg_wdata
);

    localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int OPA_W = irs_pkg::OPA_W;
    localparam int OPB_W = irs_pkg::OPB_W;
    localparam int RES_W = irs_pkg::RES_W;

    irs_pkg::state_t state_reg, state_next;
    irs_pkg::mode_t  mode_reg;

    logic [1:0]  cfg_mode_reg;
    logic [8:0]  cfg_width_reg;
    logic [8:0]  cfg_height_reg;
    logic [2:0]  cfg_chan_reg;
    logic [24:0] cfg_xstep_reg;
    logic [24:0] cfg_ystep_reg;

    logic [11:0]          row_reg;
    logic [11:0]          col_reg;
    logic [1:0]           ch_reg;
    logic [XW-1:0]        xi_reg;
    logic [YW-1:0]        yi_reg;
    logic [FRAC_BITS-1:0] xf_reg;
    logic [FRAC_BITS-1:0] yf_reg;
    logic [1:0]           cnt_reg;
    logic [1:0]           rowi_reg;
    logic [2:0]           op_reg;
    logic                 colp_reg;
    logic                 cap_v_reg;
    logic [1:0]           cap_idx_reg;
    logic [7:0]           value_reg;
    logic signed [OPA_W-1:0] p_reg [4];
    logic signed [OPA_W-1:0] t_reg [4];
    logic signed [OPA_W-1:0] tmp_reg;

    logic [8:0] w_sat;
    logic [8:0] h_sat;
    logic [2:0] nch_sat;
    logic       accept;
    logic       query_absent;
    logic       load_ok;
    logic       read_last;

    logic [12:0] xs [4];
    logic [12:0] ys [4];
    logic [12:0] xk;
    logic [12:0] yk;
    logic [12:0] rd_r;
    logic [12:0] rd_c;

    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic          mem_re;
    logic [7:0]    mem_rdata;

    irs_pkg::alu_req_t       alu_req;
    logic signed [RES_W-1:0] alu_res;

    logic signed [OPA_W-1:0] q [4];
    logic signed [OPA_W-1:0] coef_a;
    logic signed [OPA_W-1:0] coef_b;
    logic signed [OPA_W-1:0] coef_c;
    logic [FRAC_BITS-1:0]    cub_t;
    logic [FRAC_BITS:0]      one_xf;
    logic [FRAC_BITS:0]      one_yf;
    logic [RES_W-1:0]        pos_ip;
    logic [7:0]              final_value;

    function automatic logic [AW-1:0] addr_of(input logic [12:0] r, input logic [12:0] c,
                                              input logic [1:0] k);
        logic [AW-1:0] pix;
        pix = AW'(r) * AW'(MAX_WIDTH) + AW'(c);
        return pix * AW'(MAX_CHANNELS) + AW'(k);
    endfunction

    // Size registers saturated to 1..MAX
    always_comb begin
        if (cfg_width_reg == 9'd0) begin
            w_sat = 9'd1;
        end else if (32'(cfg_width_reg) > MAX_WIDTH) begin
            w_sat = 9'(MAX_WIDTH);
        end else begin
            w_sat = cfg_width_reg;
        end
        if (cfg_height_reg == 9'd0) begin
            h_sat = 9'd1;
        end else if (32'(cfg_height_reg) > MAX_HEIGHT) begin
            h_sat = 9'(MAX_HEIGHT);
        end else begin
            h_sat = cfg_height_reg;
        end
        if (cfg_chan_reg == 3'd0) begin
            nch_sat = 3'd1;
        end else if (32'(cfg_chan_reg) > MAX_CHANNELS) begin
            nch_sat = 3'(MAX_CHANNELS);
        end else begin
            nch_sat = cfg_chan_reg;
        end
    end

    assign accept       = s_valid && s_ready;
    assign query_absent = {1'b0, s_channel} >= nch_sat;
    assign load_ok      = (32'(s_row) < MAX_HEIGHT) && (32'(s_col) < MAX_WIDTH)
                          && (32'(s_channel) < MAX_CHANNELS);
    assign read_last    = (mode_reg == irs_pkg::M_NEAREST) || (cnt_reg == 2'd3);

    // Neighbour coordinates with edge repeat
    always_comb begin
        xs[1] = 13'(xi_reg);
        ys[1] = 13'(yi_reg);
        xs[0] = (xi_reg == '0) ? xs[1] : xs[1] - 13'd1;
        ys[0] = (yi_reg == '0) ? ys[1] : ys[1] - 13'd1;
        xs[2] = (xs[1] + 13'd2 >= 13'(w_sat)) ? xs[1] : xs[1] + 13'd1;
        ys[2] = (ys[1] + 13'd2 >= 13'(h_sat)) ? ys[1] : ys[1] + 13'd1;
        xs[3] = (xs[1] + 13'd3 >= 13'(w_sat)) ? xs[1] : xs[1] + 13'd2;
        ys[3] = (ys[1] + 13'd3 >= 13'(h_sat)) ? ys[1] : ys[1] + 13'd2;
        xk    = (xs[1] + 13'd1 == 13'(w_sat)) ? xs[1] : xs[1] + 13'd1;
        yk    = (ys[1] + 13'd1 == 13'(h_sat)) ? ys[1] : ys[1] + 13'd1;
        case (mode_reg)
            irs_pkg::M_BICUBIC: begin
                rd_r = ys[rowi_reg];
                rd_c = xs[cnt_reg];
            end
            irs_pkg::M_BILINEAR: begin
                rd_r = cnt_reg[1] ? yk : ys[1];
                rd_c = cnt_reg[0] ? xk : xs[1];
            end
            default: begin
                rd_r = ys[1];
                rd_c = xs[1];
            end
        endcase
    end

    // Cubic coefficients over the current four points
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            q[i] = colp_reg ? t_reg[i] : p_reg[i];
        end
        coef_a = q[3] - q[2] - q[0] + q[1];
        coef_b = q[0] - q[1] - coef_a;
        coef_c = q[2] - q[0];
        cub_t  = colp_reg ? yf_reg : xf_reg;
        one_xf = (FRAC_BITS+1)'(1) << FRAC_BITS;
        one_xf = one_xf - (FRAC_BITS+1)'(xf_reg);
        one_yf = (FRAC_BITS+1)'(1) << FRAC_BITS;
        one_yf = one_yf - (FRAC_BITS+1)'(yf_reg);
        pos_ip = RES_W'(alu_res) >> FRAC_BITS;
    end

    always_comb begin
        case (mode_reg)
            irs_pkg::M_BICUBIC: begin
                if (alu_res < 0) begin
                    final_value = 8'd0;
                end else if (alu_res > (RES_W'(255) <<< FRAC_BITS)) begin
                    final_value = 8'd255;
                end else begin
                    final_value = 8'(alu_res >>> FRAC_BITS);
                end
            end
            irs_pkg::M_BILINEAR: final_value = 8'(alu_res >>> (2 * FRAC_BITS));
            default:             final_value = p_reg[0][7:0];
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            irs_pkg::ST_IDLE: begin
                if (accept && s_func) begin
                    state_next = query_absent ? irs_pkg::ST_DONE : irs_pkg::ST_POSX;
                end
            end
            irs_pkg::ST_POSX:  state_next = irs_pkg::ST_POSY;
            irs_pkg::ST_POSY:  state_next = irs_pkg::ST_POSL;
            irs_pkg::ST_POSL:  state_next = irs_pkg::ST_READ;
            irs_pkg::ST_READ: begin
                if (read_last) begin
                    state_next = irs_pkg::ST_RWAIT;
                end
            end
            irs_pkg::ST_RWAIT: begin
                case (mode_reg)
                    irs_pkg::M_BICUBIC:  state_next = irs_pkg::ST_CUBIC;
                    irs_pkg::M_BILINEAR: state_next = irs_pkg::ST_BILIN;
                    default:             state_next = irs_pkg::ST_FINAL;
                endcase
            end
            irs_pkg::ST_CUBIC: begin
                if (op_reg == 3'd2) begin
                    state_next = colp_reg ? irs_pkg::ST_FINAL : irs_pkg::ST_CSTORE;
                end
            end
            irs_pkg::ST_CSTORE: begin
                state_next = (rowi_reg == 2'd3) ? irs_pkg::ST_CUBIC : irs_pkg::ST_READ;
            end
            irs_pkg::ST_BILIN: begin
                if (op_reg == 3'd5) begin
                    state_next = irs_pkg::ST_FINAL;
                end
            end
            irs_pkg::ST_FINAL: state_next = irs_pkg::ST_DONE;
            irs_pkg::ST_DONE: begin
                if (m_ready) begin
                    state_next = irs_pkg::ST_IDLE;
                end
            end
            default: state_next = irs_pkg::ST_IDLE;
        endcase
    end

    // Outputs: handshake, store access and unit requests
    always_comb begin
        s_ready     = (state_reg == irs_pkg::ST_IDLE);
        m_valid     = (state_reg == irs_pkg::ST_DONE);
        mem_we      = accept && !s_func && load_ok;
        mem_re      = (state_reg == irs_pkg::ST_READ);
        mem_addr    = mem_we ? addr_of(13'(s_row), 13'(s_col), s_channel)
                             : addr_of(rd_r, rd_c, ch_reg);
        alu_req     = '0;
        case (state_reg)
            irs_pkg::ST_POSX: begin
                alu_req.en = 1'b1;
                alu_req.a  = OPA_W'(col_reg);
                alu_req.b  = OPB_W'(cfg_xstep_reg);
            end
            irs_pkg::ST_POSY: begin
                alu_req.en = 1'b1;
                alu_req.a  = OPA_W'(row_reg);
                alu_req.b  = OPB_W'(cfg_ystep_reg);
            end
            irs_pkg::ST_CUBIC: begin
                alu_req.en    = 1'b1;
                alu_req.shift = 1'b1;
                alu_req.b     = OPB_W'(cub_t);
                case (op_reg)
                    3'd0: begin
                        alu_req.a = coef_a;
                        alu_req.c = RES_W'(coef_b);
                    end
                    3'd1: begin
                        alu_req.a = OPA_W'(alu_res);
                        alu_req.c = RES_W'(coef_c);
                    end
                    default: begin
                        alu_req.a = OPA_W'(alu_res);
                        alu_req.c = RES_W'(q[1]);
                    end
                endcase
            end
            irs_pkg::ST_BILIN: begin
                alu_req.en = 1'b1;
                case (op_reg)
                    3'd0: begin
                        alu_req.a = p_reg[0];
                        alu_req.b = OPB_W'(one_xf);
                    end
                    3'd1: begin
                        alu_req.a = p_reg[1];
                        alu_req.b = OPB_W'(xf_reg);
                        alu_req.c = alu_res;
                    end
                    3'd2: begin
                        alu_req.a = p_reg[2];
                        alu_req.b = OPB_W'(one_xf);
                    end
                    3'd3: begin
                        alu_req.a = p_reg[3];
                        alu_req.b = OPB_W'(xf_reg);
                        alu_req.c = alu_res;
                    end
                    3'd4: begin
                        alu_req.a = OPA_W'(alu_res);
                        alu_req.b = OPB_W'(yf_reg);
                    end
                    default: begin
                        alu_req.a = tmp_reg;
                        alu_req.b = OPB_W'(one_yf);
                        alu_req.c = alu_res;
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= irs_pkg::ST_IDLE;
            cap_v_reg      <= 1'b0;
            cfg_mode_reg   <= irs_pkg::MODE_CODE_NEAREST;
            cfg_width_reg  <= 9'd256;
            cfg_height_reg <= 9'd256;
            cfg_chan_reg   <= 3'd4;
            cfg_xstep_reg  <= 25'd65536;
            cfg_ystep_reg  <= 25'd65536;
        end else begin
            state_reg <= state_next;
            cap_v_reg <= mem_re;
            if (cfg_wen) begin
                case (cfg_index)
                    irs_pkg::CFG_MODE:    cfg_mode_reg   <= cfg_wdata[1:0];
                    irs_pkg::CFG_WIDTH:   cfg_width_reg  <= cfg_wdata[8:0];
                    irs_pkg::CFG_HEIGHT:  cfg_height_reg <= cfg_wdata[8:0];
                    irs_pkg::CFG_CHANNEL: cfg_chan_reg   <= cfg_wdata[2:0];
                    irs_pkg::CFG_XSTEP:   cfg_xstep_reg  <= cfg_wdata;
                    irs_pkg::CFG_YSTEP:   cfg_ystep_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        cap_idx_reg <= cnt_reg;
        if (cap_v_reg) begin
            p_reg[cap_idx_reg] <= (mode_reg == irs_pkg::M_BICUBIC)
                                  ? (OPA_W'(mem_rdata) <<< FRAC_BITS) : OPA_W'(mem_rdata);
        end
        case (state_reg)
            irs_pkg::ST_IDLE: begin
                if (accept && s_func) begin
                    row_reg   <= s_row;
                    col_reg   <= s_col;
                    ch_reg    <= s_channel;
                    value_reg <= 8'd0;
                    case (cfg_mode_reg)
                        irs_pkg::MODE_CODE_BILINEAR: mode_reg <= irs_pkg::M_BILINEAR;
                        irs_pkg::MODE_CODE_BICUBIC:  mode_reg <= irs_pkg::M_BICUBIC;
                        default:                     mode_reg <= irs_pkg::M_NEAREST;
                    endcase
                end
            end
            irs_pkg::ST_POSY: begin
                if (pos_ip >= RES_W'(w_sat)) begin
                    xi_reg <= XW'(w_sat - 9'd1);
                    xf_reg <= '0;
                end else begin
                    xi_reg <= pos_ip[XW-1:0];
                    xf_reg <= alu_res[FRAC_BITS-1:0];
                end
            end
            irs_pkg::ST_POSL: begin
                if (pos_ip >= RES_W'(h_sat)) begin
                    yi_reg <= YW'(h_sat - 9'd1);
                    yf_reg <= '0;
                end else begin
                    yi_reg <= pos_ip[YW-1:0];
                    yf_reg <= alu_res[FRAC_BITS-1:0];
                end
                cnt_reg  <= 2'd0;
                rowi_reg <= 2'd0;
                op_reg   <= 3'd0;
                colp_reg <= 1'b0;
            end
            irs_pkg::ST_READ: begin
                cnt_reg <= read_last ? 2'd0 : cnt_reg + 2'd1;
            end
            irs_pkg::ST_CUBIC: begin
                op_reg <= (op_reg == 3'd2) ? 3'd0 : op_reg + 3'd1;
            end
            irs_pkg::ST_CSTORE: begin
                t_reg[rowi_reg] <= OPA_W'(alu_res);
                rowi_reg        <= rowi_reg + 2'd1;
                if (rowi_reg == 2'd3) begin
                    colp_reg <= 1'b1;
                end
            end
            irs_pkg::ST_BILIN: begin
                op_reg <= op_reg + 3'd1;
                if (op_reg == 3'd2) begin
                    tmp_reg <= OPA_W'(alu_res);
                end
            end
            irs_pkg::ST_FINAL: begin
                value_reg <= final_value;
            end
            default: ;
        endcase
    end

    assign m_value = value_reg;

    irs_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (s_sample),
        .rdata (mem_rdata)
    );

    irs_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .aclk (aclk),
        .req  (alu_req),
        .res  (alu_res)
    );

endmodule
`default_nettype wire

FILE: rtl/irs_chk.sv
// Port-level checker for the image resample interpolator, bound to the top level.
`default_nettype none
module irs_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        s_func,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [7:0]  m_value
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("ready while a result is pending");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_func |=> !s_ready)
        else $error("query did not occupy the block");

    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_func |=> s_ready && !m_valid)
        else $error("load item produced a result or stalled");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> !m_valid)
        else $error("result item repeated");

endmodule

bind image_resample_interpolator irs_chk u_irs_chk (.*);
`default_nettype wire
